// ===== hw/rtl/hte_pkg.sv =====
package hte_pkg;

    typedef enum logic [1:0] {
        REQ_WR_CUR  = 2'd0,
        REQ_WR_OPND = 2'd1,
        REQ_COMPOSE = 2'd2,
        REQ_XFORM   = 2'd3
    } t_req;

    localparam int unsigned MAXDIM = 4;
    localparam int unsigned IDXW   = 2;
    localparam int unsigned DW     = 32;
    // four 64-bit products floored by FRAC_BITS sum within 66-FRAC_BITS bits, so 64 bits hold for FRAC_BITS >= 2
    localparam int unsigned ACCW   = 64;

    // controller -> datapath commands
    typedef struct packed {
        logic            load_vec;
        logic            wr_cur;
        logic            wr_opnd;
        logic [IDXW-1:0] wr_row;
        logic [IDXW-1:0] wr_col;
        logic            xf_step;
        logic            xf_clear;
        logic            xf_done;
        logic            cp_step;
        logic            cp_clear;
        logic            cp_commit;
        logic [IDXW-1:0] cp_col;
        logic [IDXW-1:0] cp_k;
    } t_cmd;

endpackage

// ===== hw/rtl/hte_datapath.sv =====
module hte_datapath #(
    parameter int unsigned DIM       = 4,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  hte_pkg::t_cmd                 i_cmd,
    input  logic [hte_pkg::IDXW-1:0]      i_step,
    input  logic signed [hte_pkg::DW-1:0] i_value,
    input  logic signed [hte_pkg::DW-1:0] i_vec [hte_pkg::MAXDIM],
    output logic signed [hte_pkg::DW-1:0] o_res [hte_pkg::MAXDIM],
    output logic                          o_sat
);
    localparam int unsigned N  = hte_pkg::MAXDIM;
    localparam int unsigned W  = hte_pkg::DW;
    localparam int unsigned AW = hte_pkg::ACCW;
    localparam logic signed [W-1:0] ONE = W'(1) <<< FRAC_BITS;
    localparam logic signed [AW-1:0] SMAX = (AW'(1) <<< (W-1)) - AW'(1);
    localparam logic signed [AW-1:0] SMIN = -SMAX - AW'(1);

    logic signed [W-1:0]  r_cur  [N][N];
    logic signed [W-1:0]  r_opnd [N][N];
    logic signed [W-1:0]  r_vec  [N];
    logic signed [AW-1:0] r_acc  [N];
    logic signed [W-1:0]  r_res  [N];
    logic                 r_sat;
    logic signed [W-1:0]  mul_b;
    logic signed [W-1:0]  mul_a [N];
    logic signed [2*W-1:0] prod [N];
    logic signed [AW-1:0]  n_acc [N];

    // transform: lane j takes M(k,j)*v_k; compose works one column j at a time,
    // lane i takes B(i,k)*M(k,j), so a committed column never feeds a later one
    always_comb begin
        if (i_cmd.cp_step) begin
            mul_b = r_cur[i_cmd.cp_k][i_cmd.cp_col];
            for (int i = 0; i < N; i++) mul_a[i] = r_opnd[i][i_cmd.cp_k];
        end else begin
            mul_b = r_vec[i_step];
            for (int i = 0; i < N; i++) mul_a[i] = r_cur[i_step][i];
        end
        for (int j = 0; j < N; j++) begin
            prod[j]  = mul_a[j] * mul_b;
            // arithmetic shift is floor division
            n_acc[j] = r_acc[j] + AW'(prod[j] >>> FRAC_BITS);
        end
    end

    function automatic logic signed [W-1:0] sat(input logic signed [AW-1:0] s);
        if (s > SMAX)      sat = 32'sh7fffffff;
        else if (s < SMIN) sat = 32'sh80000000;
        else               sat = s[W-1:0];
    endfunction

    function automatic logic ovf(input logic signed [AW-1:0] s);
        ovf = (s > SMAX) || (s < SMIN);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++)
                for (int j = 0; j < N; j++)
                    r_cur[i][j] <= (i == j && i < DIM) ? ONE : '0;
        end else begin
            if (i_cmd.wr_cur)
                r_cur[i_cmd.wr_row][i_cmd.wr_col] <= i_value;
            if (i_cmd.cp_commit)
                for (int i = 0; i < N; i++)
                    if (i < DIM) r_cur[i][i_cmd.cp_col] <= sat(r_acc[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_opnd)
            r_opnd[i_cmd.wr_row][i_cmd.wr_col] <= i_value;
        if (i_cmd.load_vec)
            for (int i = 0; i < N; i++) r_vec[i] <= i_vec[i];
        for (int j = 0; j < N; j++) begin
            if (i_cmd.xf_clear || i_cmd.cp_clear) r_acc[j] <= '0;
            else if (i_cmd.xf_step || i_cmd.cp_step) r_acc[j] <= n_acc[j];
        end
        if (i_cmd.xf_done) begin
            r_sat <= 1'b0;
            for (int j = 0; j < N; j++) begin
                r_res[j] <= (j < DIM) ? sat(r_acc[j]) : '0;
                if (j < DIM && ovf(r_acc[j])) r_sat <= 1'b1;
            end
        end
    end

    assign o_res = r_res;
    assign o_sat = r_sat;
endmodule

// ===== hw/rtl/hte_ctrl.sv =====
module hte_ctrl #(
    parameter int unsigned DIM = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    input  hte_pkg::t_req            i_req,
    input  logic [hte_pkg::IDXW-1:0] i_row,
    input  logic [hte_pkg::IDXW-1:0] i_col,
    output logic                     o_ready,
    output hte_pkg::t_cmd            o_cmd,
    output logic [hte_pkg::IDXW-1:0] o_step,
    output logic                     o_out_valid,
    input  logic                     i_out_ready
);
    localparam int unsigned IW = hte_pkg::IDXW;
    localparam logic [IW-1:0] LAST = IW'(DIM - 1);

    typedef enum logic [2:0] {S_IDLE, S_XFORM, S_COMPOSE, S_CP_COMMIT, S_DONE} t_state;

    t_state        r_state;
    logic [IW-1:0] r_k;
    logic [IW-1:0] r_i;
    logic          r_out_valid;
    logic          acc;

    assign acc         = i_valid && o_ready;
    // a pending result may wait while writes or a compose are taken; not a new transform
    assign o_ready     = (r_state == S_IDLE) &&
                         !(r_out_valid && !i_out_ready && i_req == hte_pkg::REQ_XFORM);
    assign o_out_valid = r_out_valid;
    assign o_step      = r_k;

    always_comb begin
        o_cmd = '0;
        o_cmd.wr_row   = i_row;
        o_cmd.wr_col   = i_col;
        o_cmd.cp_col   = r_i;
        o_cmd.cp_k     = r_k;
        o_cmd.load_vec = acc && i_req == hte_pkg::REQ_XFORM;
        o_cmd.xf_clear = o_cmd.load_vec;
        o_cmd.cp_clear = (acc && i_req == hte_pkg::REQ_COMPOSE) || r_state == S_CP_COMMIT;
        if (acc && 32'(i_row) < DIM && 32'(i_col) < DIM) begin
            o_cmd.wr_cur  = i_req == hte_pkg::REQ_WR_CUR;
            o_cmd.wr_opnd = i_req == hte_pkg::REQ_WR_OPND;
        end
        o_cmd.xf_step   = r_state == S_XFORM;
        o_cmd.xf_done   = r_state == S_DONE;
        o_cmd.cp_step   = r_state == S_COMPOSE;
        o_cmd.cp_commit = r_state == S_CP_COMMIT;
    end

    // compose: each column accumulates over k from 0 to DIM-1, then commits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_k         <= '0;
            r_i         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_out_ready) r_out_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_k <= '0;
                    r_i <= '0;
                    if (acc && i_req == hte_pkg::REQ_XFORM)   r_state <= S_XFORM;
                    if (acc && i_req == hte_pkg::REQ_COMPOSE) r_state <= S_COMPOSE;
                end
                S_XFORM: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == LAST) r_state <= S_DONE;
                end
                S_DONE: begin
                    r_out_valid <= 1'b1;
                    r_state     <= S_IDLE;
                end
                S_COMPOSE: begin
                    if (r_k == LAST) r_state <= S_CP_COMMIT;
                    else             r_k <= r_k + 1'b1;
                end
                S_CP_COMMIT: begin
                    r_k <= '0;
                    r_i <= r_i + 1'b1;
                    r_state <= (r_i == LAST) ? S_IDLE : S_COMPOSE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hw/rtl/homogeneous_transform_engine.sv =====
// Homogeneous transform engine, Q(32-FRAC_BITS).FRAC_BITS signed. Holds a
// current matrix (identity after reset) and an operand matrix. A transform
// feeds one vector component a beat through four multiply-accumulate lanes,
// then saturates the sums into the output register; the next request is taken
// once the engine is back in idle. A compose reuses the same lanes column by
// column, accumulating and then committing each column. One request is in
// flight at a time; a finished result waits in an output register while
// writes and composes proceed.
module homogeneous_transform_engine #(
    parameter int unsigned DIM       = 4,
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // req_type[1:0], elem_row[3:2], elem_col[5:4], elem_value[37:6],
    // vec_x[69:38], vec_y[101:70], vec_z[133:102], vec_w[165:134], zero fill
    input  logic [167:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64], out_w[127:96]
    output logic [127:0] m_axis_tdata,
    // out_saturated[0]
    output logic         m_axis_tuser
);
    hte_pkg::t_cmd            cmd;
    logic [hte_pkg::IDXW-1:0] step;
    logic signed [31:0]       vec [hte_pkg::MAXDIM];
    logic signed [31:0]       res [hte_pkg::MAXDIM];
    logic                     sat;

    always_comb
        for (int i = 0; i < hte_pkg::MAXDIM; i++)
            vec[i] = s_axis_tdata[38 + 32*i +: 32];

    hte_ctrl #(.DIM(DIM)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .i_req       (hte_pkg::t_req'(s_axis_tdata[1:0])),
        .i_row       (s_axis_tdata[3:2]),
        .i_col       (s_axis_tdata[5:4]),
        .o_ready     (s_axis_tready),
        .o_cmd       (cmd),
        .o_step      (step),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready)
    );

    hte_datapath #(.DIM(DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_step  (step),
        .i_value (s_axis_tdata[37:6]),
        .i_vec   (vec),
        .o_res   (res),
        .o_sat   (sat)
    );

    assign m_axis_tdata = {res[3], res[2], res[1], res[0]};
    assign m_axis_tuser = sat;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.xf_step && cmd.cp_step))
        else $error("transform and compose overlap");
    a_no_xform_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.xf_done |-> !m_axis_tvalid || m_axis_tready)
        else $error("pending result overwritten");
endmodule
